[src/ucfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared types, constants and helpers of the uart command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

	localparam int FRAME_LEN    = 5;
	localparam int BUFFER_LIMIT = 9;
	localparam int CNT_W        = $clog2(BUFFER_LIMIT + 1);
	localparam int NUM_CMDS     = 18;

	localparam logic [7:0] START_MARK = 8'hAF;
	localparam logic [7:0] END_MARK   = 8'hDF;
	localparam logic [7:0] BROADCAST  = 8'hFF;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam int         REG_IDX_W    = 1;
	localparam int         CFG_DATA_W   = 16;
	localparam logic [0:0] REG_OWN_ADDR = 1'd0;
	localparam logic [0:0] REG_GAP      = 1'd1;

	localparam logic [7:0]  OWN_ADDR_RST = 8'hFF;
	localparam logic [15:0] GAP_RST      = 16'd10;

	typedef enum logic [2:0] {
		V_DISPATCHED = 3'd0,
		V_WRONG_LEN  = 3'd1,
		V_BAD_DELIM  = 3'd2,
		V_NOT_ADDR   = 3'd3,
		V_UNKNOWN    = 3'd4
	} verdict_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_buf_t;

	// snapshot of a closed frame window
	typedef struct packed {
		frame_buf_t       bytes;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} push_t;

	localparam logic [NUM_CMDS-1:0][7:0] KNOWN_CMDS = {
		8'hEC, 8'hEB, 8'hEA, 8'hE9, 8'hE8, 8'hE7, 8'hE6, 8'hE5,
		8'h0A, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01
	};

	function automatic logic is_known(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_CMDS; i++) begin
			if (KNOWN_CMDS[i] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

	// byte at a frame position, zero if not received or beyond the frame
	function automatic logic [7:0] frame_at(input frame_buf_t b,
			input logic [CNT_W-1:0] cnt, input int pos);
		logic [7:0] v;
		v = 8'd0;
		for (int i = 0; i < FRAME_LEN; i++) begin
			if (i == pos && CNT_W'(i) < cnt)
				v = b[i];
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[src/ucfp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp channel interfaces
// Valid/ready channels for input items and verdict results.
// ----------------------------------------------------------------------------
interface ucfp_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ucfp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [7:0] command_code;
	logic [7:0] argument;
	logic [7:0] target_address;
	logic       overflowed;

	modport source (output valid, output verdict, output command_code, output argument,
		output target_address, output overflowed, input ready);
	modport sink   (input valid, input verdict, input command_code, input argument,
		input target_address, input overflowed, output ready);
endinterface
`default_nettype wire

[src/ucfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_front
// Takes byte and tick beats, fills the frame buffer, times the window and
// pushes a frame snapshot into the queue when the window closes.
// ----------------------------------------------------------------------------
module ucfp_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire                     opcode,
	input  wire  [7:0]              rx_byte,
	input  wire  [15:0]             gap_ticks,
	input  wire                     q_full,
	output ucfp_pkg::push_t         push
);

	localparam int CW = ucfp_pkg::CNT_W;

	ucfp_pkg::frame_buf_t fb_q;
	logic [CW-1:0]        count_q;
	logic [15:0]          ticks_q;
	logic                 ovf_q;

	logic        take;
	logic [15:0] limit;
	logic [16:0] ticks_inc;
	logic        closing;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	assign limit     = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
	assign ticks_inc = {1'b0, ticks_q} + 17'd1;
	assign closing   = take && (opcode == ucfp_pkg::OP_TICK) && (count_q != '0)
		&& (ticks_inc >= {1'b0, limit});

	assign push.valid     = closing;
	assign push.rec.bytes = fb_q;
	assign push.rec.count = count_q;
	assign push.rec.ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ticks_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (opcode == ucfp_pkg::OP_BYTE) begin
				if (count_q < CW'(ucfp_pkg::BUFFER_LIMIT)) begin
					if (count_q == '0)
						ticks_q <= '0;
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else if (count_q != '0) begin
				if (closing) begin
					count_q <= '0;
					ticks_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					ticks_q <= ticks_inc[15:0];
				end
			end
		end
	end

	// frame buffer, no reset: positions past the count are masked downstream
	always_ff @(posedge clk) begin
		if (take && opcode == ucfp_pkg::OP_BYTE) begin
			for (int i = 0; i < ucfp_pkg::FRAME_LEN; i++) begin
				if (count_q == CW'(i))
					fb_q[i] <= rx_byte;
			end
		end
	end

endmodule
`default_nettype wire

[src/ucfp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_queue
// Two-entry queue of closed frame snapshots between front and back.
// ----------------------------------------------------------------------------
module ucfp_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ucfp_pkg::push_t     push,
	output logic                     full,
	output logic                     pop_valid,
	input  wire                      pop_ready,
	output ucfp_pkg::frame_rec_t     pop_rec
);

	ucfp_pkg::frame_rec_t mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;

	logic do_push;
	logic do_pop;

	assign full      = (fill_q == 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_rec   = mem_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.rec;
	end

endmodule
`default_nettype wire

[src/ucfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfp_back
// Judges a closed frame and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module ucfp_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rec_valid,
	output logic                  rec_ready,
	input  wire ucfp_pkg::frame_rec_t rec,
	input  wire  [7:0]            own_address,
	ucfp_out_if.source            out_ch
);

	logic       valid_q;
	logic [2:0] verdict_q;
	logic [7:0] cmd_q;
	logic [7:0] arg_q;
	logic [7:0] addr_q;
	logic       ovf_q;

	logic [7:0]         addr;
	logic [7:0]         cmd;
	logic [7:0]         arg;
	logic [7:0]         first_b;
	logic [7:0]         last_b;
	ucfp_pkg::verdict_t v;

	assign addr    = ucfp_pkg::frame_at(rec.bytes, rec.count, 1);
	assign cmd     = ucfp_pkg::frame_at(rec.bytes, rec.count, 2);
	assign arg     = ucfp_pkg::frame_at(rec.bytes, rec.count, 3);
	assign first_b = ucfp_pkg::frame_at(rec.bytes, rec.count, 0);
	assign last_b  = ucfp_pkg::frame_at(rec.bytes, rec.count, ucfp_pkg::FRAME_LEN - 1);

	always_comb begin
		if (rec.count != ucfp_pkg::CNT_W'(ucfp_pkg::FRAME_LEN))
			v = ucfp_pkg::V_WRONG_LEN;
		else if (first_b != ucfp_pkg::START_MARK || last_b != ucfp_pkg::END_MARK)
			v = ucfp_pkg::V_BAD_DELIM;
		else if (addr != ucfp_pkg::BROADCAST && addr != own_address)
			v = ucfp_pkg::V_NOT_ADDR;
		else if (!ucfp_pkg::is_known(cmd))
			v = ucfp_pkg::V_UNKNOWN;
		else
			v = ucfp_pkg::V_DISPATCHED;
	end

	assign rec_ready = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			verdict_q <= v;
			cmd_q     <= cmd;
			arg_q     <= arg;
			addr_q    <= addr;
			ovf_q     <= rec.ovf;
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.verdict        = verdict_q;
	assign out_ch.command_code   = cmd_q;
	assign out_ch.argument       = arg_q;
	assign out_ch.target_address = addr_q;
	assign out_ch.overflowed     = ovf_q;

endmodule
`default_nettype wire

[src/uart_command_frame_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_frame_parser_unit
// Collects received bytes into frames, closes each frame after a tick gap
// and reports one verdict per frame.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                            | beat
//  in_ch    | in  | opcode, rx_byte                                    | byte or tick
//  out_ch   | out | verdict, command_code, argument, target_address,   | one per frame
//           |     | overflowed                                         |
//  cfg      | in  | wr_en, wr_index, wr_data                           | register write
//
//  one input beat per cycle while the frame queue is not full; a verdict
//  for the closing tick passes the queue, then the output register
//  in_ch.ready drops only while the two-entry frame queue is full
//  out_ch stalls fill the queue first, then hold off every input beat
//  arst_n clears counters, queue and output valid; own_address resets to 0xFF
//  and gap_ticks to 10
// ----------------------------------------------------------------------------
module uart_command_frame_parser_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	ucfp_in_if.sink                               in_ch,
	ucfp_out_if.source                            out_ch,
	input  wire                                   wr_en,
	input  wire  [ucfp_pkg::REG_IDX_W-1:0]        wr_index,
	input  wire  [ucfp_pkg::CFG_DATA_W-1:0]       wr_data
);

	logic [7:0]  own_addr_q;
	logic [15:0] gap_q;

	ucfp_pkg::push_t      push;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_ready;
	ucfp_pkg::frame_rec_t q_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= ucfp_pkg::OWN_ADDR_RST;
			gap_q      <= ucfp_pkg::GAP_RST;
		end else if (wr_en) begin
			case (wr_index)
				ucfp_pkg::REG_OWN_ADDR: own_addr_q <= wr_data[7:0];
				ucfp_pkg::REG_GAP:      gap_q      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	ucfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.opcode    (in_ch.opcode),
		.rx_byte   (in_ch.rx_byte),
		.gap_ticks (gap_q),
		.q_full    (q_full),
		.push      (push)
	);

	ucfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_rec   (q_rec)
	);

	ucfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (q_valid),
		.rec_ready   (q_ready),
		.rec         (q_rec),
		.own_address (own_addr_q),
		.out_ch      (out_ch)
	);

endmodule
`default_nettype wire
